[rtl/shb_pkg.sv]
// shared types, constants and the hash mixing function for the string hash block
package shb_pkg;

	localparam int unsigned HashW   = 32;
	localparam int unsigned BucketW = 24;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned CntW    = 5;

	localparam logic [BucketW-1:0] BucketReset = 24'd101;
	localparam logic [CntW-1:0]    DivSteps    = 5'd31;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} shb_state_t;

	typedef struct packed {
		logic hash_upd;
		logic start;
		logic div_step;
		logic out_load;
	} shb_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} shb_sts_t;

	function automatic logic [HashW-1:0] mix_byte(input logic [HashW-1:0] h,
		input logic [ByteW-1:0] b);
		logic [HashW-1:0] sum;
		logic [3:0]       top;
		sum = {h[HashW-5:0], 4'b0000} + {{(HashW-ByteW){b[ByteW-1]}}, b};
		top = sum[HashW-1:HashW-4];
		return {4'b0000, sum[HashW-5:8], sum[7:4] ^ top, sum[3:0]};
	endfunction

endpackage

[rtl/shb_ctrl.sv]
// controller state machine sequencing byte updates, the modulo and the result load
module shb_ctrl import shb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     last,
	output logic     in_stall,
	input  shb_sts_t sts,
	output shb_cmd_t cmd
);

	shb_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (last) begin
						cmd.start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						cmd.hash_upd = 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/shb_dp.sv]
// datapath: bucket count register, running hash, bit-serial divider and result register
module shb_dp import shb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [BucketW-1:0] cfg_wr_data,
	input  logic [ByteW-1:0]   key_byte,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [BucketW-1:0] bucket_index,
	output logic [HashW-1:0]   raw_hash,
	input  shb_cmd_t           cmd,
	output shb_sts_t           sts
);

	logic [BucketW-1:0] num_buckets_q;
	logic [HashW-1:0]   hash_q;
	logic [HashW-1:0]   hash_next;
	logic [HashW-1:0]   raw_q;
	logic [HashW-1:0]   dvd_q;
	logic [BucketW-1:0] rem_q;
	logic [BucketW-1:0] div_q;
	logic [CntW-1:0]    cnt_q;
	logic               out_valid_q;
	logic [BucketW-1:0] bucket_index_q;
	logic [HashW-1:0]   raw_hash_q;
	logic [BucketW:0]   trial;
	logic [BucketW:0]   diff;

	assign hash_next = (key_byte != '0) ? mix_byte(hash_q, key_byte) : hash_q;

	assign trial = {rem_q, dvd_q[HashW-1]};
	assign diff  = trial - {1'b0, div_q};

	assign sts.div_last = (cnt_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_buckets_q <= BucketReset;
			hash_q        <= '0;
			out_valid_q   <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (cfg_wr_en) begin
				num_buckets_q <= cfg_wr_data;
			end
			if (cmd.hash_upd) begin
				hash_q <= hash_next;
			end else if (cmd.start) begin
				hash_q <= '0;
			end
			if (cmd.start) begin
				cnt_q <= DivSteps;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			raw_q <= hash_next;
			dvd_q <= hash_next;
			rem_q <= '0;
			div_q <= (num_buckets_q == '0) ? BucketW'(1) : num_buckets_q;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[HashW-2:0], 1'b0};
			rem_q <= diff[BucketW] ? trial[BucketW-1:0] : diff[BucketW-1:0];
		end
		if (cmd.out_load) begin
			bucket_index_q <= rem_q;
			raw_hash_q     <= raw_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_index_q;
	assign raw_hash     = raw_hash_q;

`ifndef SYNTH
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < div_q)
		else $error("remainder not below divisor");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while waiting");
	a_hash_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> hash_q == '0)
		else $error("running hash not cleared after key");
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.hash_upd, cmd.start, cmd.div_step, cmd.out_load}))
		else $error("conflicting datapath commands");
`endif

endmodule

[rtl/string_hash_to_bucket_top.sv]
// top level of the string hash to bucket block
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  in       | in_valid / in_stall  | key_byte[7:0], last
//  out      | out_valid / out_stall| bucket_index[23:0], raw_hash[31:0]
//  cfg      | cfg_wr_en            | cfg_wr_data[23:0] (number of buckets)
//
// a byte without last is folded into the running hash; the next byte follows directly
// a last byte loads the divider, runs the bit-serial modulo and then loads the result register
// the modulo runs on the single shared one-bit-per-cycle divider
// reset clears the running hash and control, the number of buckets returns to 101
// a held result stalls the next key end only if out_stall is still high when it finishes
module string_hash_to_bucket_top import shb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [BucketW-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ByteW-1:0]   key_byte,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [BucketW-1:0] bucket_index,
	output logic [HashW-1:0]   raw_hash
);

	shb_cmd_t cmd;
	shb_sts_t sts;

	shb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	shb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.key_byte     (key_byte),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.bucket_index (bucket_index),
		.raw_hash     (raw_hash),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
